// ===== hw/rtl/swns_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swns_pkg
// Shared types and constants of the square-wave note sequencer: command
// codes, item structs, controller states and fixed sizes.
// ----------------------------------------------------------------------------
package swns_pkg;

   // note table geometry
   localparam int NOTE_DEPTH = 64;
   localparam int NOTE_AW    = $clog2(NOTE_DEPTH);

   // period divider: one quotient bit per cycle
   localparam int DIV_STEPS  = 16;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // command codes
   localparam logic [2:0] CMD_TICK = 3'd0;
   localparam logic [2:0] CMD_LOAD = 3'd1;
   localparam logic [2:0] CMD_PLAY = 3'd2;
   localparam logic [2:0] CMD_STOP = 3'd3;
   localparam logic [2:0] CMD_MUTE = 3'd4;

   // register indexes
   localparam logic CSR_SAMPLE_RATE = 1'b0;
   localparam logic CSR_TAIL_MS     = 1'b1;

   // reset values and fixed levels
   localparam logic [15:0]        RATE_RESET   = 16'd22050;
   localparam logic [7:0]         TAIL_RESET   = 8'd25;
   localparam logic [15:0]        PERIOD_MIN   = 16'd2;
   localparam logic [16:0]        MS_STEP      = 17'd1000;
   localparam logic signed [13:0] AMP_POS      = 14'sd6000;
   localparam logic signed [13:0] AMP_NEG      = -14'sd6000;

   typedef struct packed {
      logic [2:0]  command;
      logic [5:0]  note_index;
      logic [15:0] note_hz;
      logic [15:0] note_ms;
      logic [6:0]  song_length;
      logic        repeat_req;
   } req_type;

   typedef struct packed {
      logic signed [13:0] sample;
      logic               sample_valid;
      logic               playing;
      logic               muted;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_MS,
      S_NEXT,
      S_FETCH,
      S_DIV,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/square_wave_note_sequencer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// square_wave_note_sequencer_unit
// Monophonic square-wave melody player with a 64-entry note table in RAM,
// a millisecond sequencer and an iterative tone period divider.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and exactly one result
// comes back on rsp_item, marked by rsp_valid for a single cycle; the receiver
// cannot stall it, so it must take the result in that cycle. Load, stop, toggle
// mute, play of an empty song and unknown commands go from S_EXEC straight to
// S_DONE, where the result is strobed; a sample tick that passes no note
// boundary goes through S_MS as well. No new item is taken until the result is
// strobed and the block is back in S_IDLE. Starting a note (play, or a tick that
// ends a tail) adds S_NEXT to check the song end, S_FETCH after a registered
// table RAM read and, unless the note is a rest, S_DIV for the restoring period
// divider, which produces one quotient bit per cycle. The note table has no
// reset; configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module square_wave_note_sequencer_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  swns_pkg::req_type  req_item,
   output logic               rsp_valid,
   output swns_pkg::rsp_type  rsp_item,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire                csr_index,
   input  wire  [15:0]        csr_data
);
   import swns_pkg::*;

   // controller and sequencer state
   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [15:0] rate_ff, rate_in;
   logic [7:0]  tail_ff, tail_in;
   logic [6:0]  pos_ff, pos_in;
   logic [6:0]  count_ff, count_in;
   logic        loop_ff, loop_in;
   logic        active_ff, active_in;
   logic        mute_ff, mute_in;
   logic        in_tail_ff, in_tail_in;
   logic [15:0] ms_left_ff, ms_left_in;
   logic [15:0] acc_ff, acc_in;
   logic [16:0] acc_sum_ff, acc_sum_in;
   logic        tone_on_ff, tone_on_in;
   logic [15:0] period_ff, period_in;
   logic [15:0] phase_ff, phase_in;
   logic signed [13:0] sample_ff, sample_in;
   logic        tick_ff, tick_in;

   // divider
   logic [16:0]          rem_ff, rem_in;
   logic [15:0]          quo_ff, quo_in;
   logic [15:0]          div_hz_ff, div_hz_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // note table RAM
   logic [31:0]        note_mem [NOTE_DEPTH];
   logic [31:0]        rd_data_ff;
   logic [NOTE_AW-1:0] rd_addr;
   logic               mem_we;

   // helpers
   logic [15:0] eff_rate;
   logic [16:0] rate_ext;
   logic [16:0] acc_diff;
   logic [15:0] ms_dec;
   logic [15:0] phase_inc;
   logic [16:0] div_shift;
   logic [16:0] div_diff;
   logic [15:0] quo_next;
   logic [15:0] fetch_hz;
   logic [15:0] fetch_ms;
   logic [15:0] tail_ext;
   logic        pos_end;

   assign eff_rate  = (rate_ff == 16'd0) ? 16'd1 : rate_ff;
   assign rate_ext  = {1'b0, eff_rate};
   assign acc_diff  = acc_sum_ff - rate_ext;
   assign ms_dec    = (ms_left_ff != 16'd0) ? ms_left_ff - 16'd1 : 16'd0;
   assign phase_inc = phase_ff + 16'd1;
   assign div_shift = {rem_ff[15:0], quo_ff[15]};
   assign div_diff  = div_shift - {1'b0, div_hz_ff};
   assign quo_next  = {quo_ff[14:0], ~div_diff[16]};
   assign fetch_hz  = rd_data_ff[15:0];
   assign fetch_ms  = rd_data_ff[31:16];
   assign tail_ext  = {8'd0, tail_ff};
   assign pos_end   = (pos_ff >= count_ff);

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign csr_ready = 1'b1;

   always_comb begin
      rsp_item.sample       = sample_ff;
      rsp_item.sample_valid = tick_ff;
      rsp_item.playing      = active_ff;
      rsp_item.muted        = mute_ff;
   end

   // next state and datapath
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      rate_in    = rate_ff;
      tail_in    = tail_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      loop_in    = loop_ff;
      active_in  = active_ff;
      mute_in    = mute_ff;
      in_tail_in = in_tail_ff;
      ms_left_in = ms_left_ff;
      acc_in     = acc_ff;
      acc_sum_in = acc_sum_ff;
      tone_on_in = tone_on_ff;
      period_in  = period_ff;
      phase_in   = phase_ff;
      sample_in  = sample_ff;
      tick_in    = tick_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_hz_in  = div_hz_ff;
      div_cnt_in = div_cnt_ff;
      rd_addr    = pos_ff[NOTE_AW-1:0];
      mem_we     = 1'b0;

      // configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLE_RATE: rate_in = csr_data;
            CSR_TAIL_MS:     tail_in = csr_data[7:0];
            default:         ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            sample_in = '0;
            tick_in   = 1'b0;
            state_in  = S_DONE;
            unique case (req_ff.command)
               CMD_TICK: begin
                  tick_in = 1'b1;
                  if (tone_on_ff && !mute_ff) begin
                     sample_in = (phase_ff < (period_ff >> 1)) ? AMP_POS : AMP_NEG;
                     phase_in  = (phase_inc >= period_ff) ? 16'd0 : phase_inc;
                  end
                  acc_sum_in = {1'b0, acc_ff} + MS_STEP;
                  state_in   = S_MS;
               end
               CMD_LOAD: begin
                  mem_we = (32'(req_ff.note_index) < NOTE_DEPTH);
               end
               CMD_PLAY: begin
                  count_in   = (req_ff.song_length > 7'(NOTE_DEPTH)) ?
                               7'(NOTE_DEPTH) : req_ff.song_length;
                  loop_in    = req_ff.repeat_req;
                  active_in  = 1'b1;
                  pos_in     = '0;
                  acc_in     = '0;
                  in_tail_in = 1'b0;
                  ms_left_in = '0;
                  if (req_ff.song_length == 7'd0) begin
                     tone_on_in = 1'b0;
                     period_in  = PERIOD_MIN;
                     phase_in   = '0;
                  end else begin
                     state_in = S_NEXT;
                  end
               end
               CMD_STOP: begin
                  active_in  = 1'b0;
                  in_tail_in = 1'b0;
                  ms_left_in = '0;
                  tone_on_in = 1'b0;
                  period_in  = PERIOD_MIN;
                  phase_in   = '0;
               end
               CMD_MUTE: begin
                  mute_in = ~mute_ff;
               end
               default: ;
            endcase
         end

         // settle the accumulator, then step one millisecond
         S_MS: begin
            state_in = S_DONE;
            if (acc_sum_ff >= rate_ext) begin
               acc_in = (acc_diff >= rate_ext) ? 16'd0 : acc_diff[15:0];
               if (active_ff && count_ff != 7'd0) begin
                  ms_left_in = ms_dec;
                  if (ms_dec == 16'd0) begin
                     if (!in_tail_ff) begin
                        in_tail_in = 1'b1;
                        ms_left_in = tail_ext;
                        tone_on_in = 1'b0;
                        period_in  = PERIOD_MIN;
                        phase_in   = '0;
                     end else begin
                        state_in = S_NEXT;
                     end
                  end
               end
            end else begin
               acc_in = acc_sum_ff[15:0];
            end
         end

         // wrap or end the song, else read the next note
         S_NEXT: begin
            if (pos_end && !loop_ff) begin
               active_in  = 1'b0;
               in_tail_in = 1'b0;
               ms_left_in = '0;
               tone_on_in = 1'b0;
               period_in  = PERIOD_MIN;
               phase_in   = '0;
               state_in   = S_DONE;
            end else begin
               if (pos_end) begin
                  rd_addr = '0;
                  pos_in  = '0;
               end
               state_in = S_FETCH;
            end
         end

         // load the hold time and, unless the note is a rest, launch the period divide
         S_FETCH: begin
            pos_in     = pos_ff + 7'd1;
            ms_left_in = (fetch_ms > tail_ext) ? fetch_ms - tail_ext : fetch_ms;
            in_tail_in = 1'b0;
            phase_in   = '0;
            if (fetch_hz == 16'd0) begin
               tone_on_in = 1'b0;
               period_in  = PERIOD_MIN;
               state_in   = S_DONE;
            end else begin
               rem_in     = '0;
               quo_in     = eff_rate;
               div_hz_in  = fetch_hz;
               div_cnt_in = '0;
               state_in   = S_DIV;
            end
         end

         // one restoring step per cycle
         S_DIV: begin
            rem_in     = div_diff[16] ? div_shift : div_diff;
            quo_in     = quo_next;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               tone_on_in = 1'b1;
               period_in  = (quo_next < PERIOD_MIN) ? PERIOD_MIN : quo_next;
               state_in   = S_DONE;
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rate_ff    <= RATE_RESET;
         tail_ff    <= TAIL_RESET;
         pos_ff     <= '0;
         count_ff   <= '0;
         loop_ff    <= 1'b0;
         active_ff  <= 1'b0;
         mute_ff    <= 1'b0;
         in_tail_ff <= 1'b0;
         ms_left_ff <= '0;
         acc_ff     <= '0;
         tone_on_ff <= 1'b0;
         period_ff  <= PERIOD_MIN;
         phase_ff   <= '0;
         tick_ff    <= 1'b0;
         sample_ff  <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         rate_ff    <= rate_in;
         tail_ff    <= tail_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         loop_ff    <= loop_in;
         active_ff  <= active_in;
         mute_ff    <= mute_in;
         in_tail_ff <= in_tail_in;
         ms_left_ff <= ms_left_in;
         acc_ff     <= acc_in;
         tone_on_ff <= tone_on_in;
         period_ff  <= period_in;
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         sample_ff  <= sample_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      acc_sum_ff <= acc_sum_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_hz_ff  <= div_hz_in;
   end

   // note table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[req_ff.note_index[NOTE_AW-1:0]] <= {req_ff.note_ms, req_ff.note_hz};
      end
      rd_data_ff <= note_mem[rd_addr];
   end

   // checks
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_period_min: assert property (@(posedge clock) disable iff (reset)
      period_ff >= PERIOD_MIN)
      else $error("tone period below minimum");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      tone_on_ff |-> (phase_ff < period_ff))
      else $error("wave phase outside tone period");

   a_silent_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.sample_valid) |-> (rsp_item.sample == 14'sd0))
      else $error("non-tick result carries a sample");

endmodule
`default_nettype wire

// ===== bench/tb_square_wave_note_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_square_wave_note_sequencer_unit
// Self-checking bench for the square-wave note sequencer. Commands go in
// over the start/busy port with random spacing. A local model of the melody
// player predicts the status and sample of every command, and each strobed
// result is compared field by field against the oldest prediction. The run
// goes through directed corner cases, a full 64-note table, and random songs
// under several sample-rate and tail settings.
// ----------------------------------------------------------------------------
module tb_square_wave_note_sequencer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import swns_pkg::*;

   // reserved command codes, ignored by the block
   localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
   localparam logic [2:0] CMD_RSVD_MID   = 3'd6;
   localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 40;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   req_type     req_item  = '0;
   logic        csr_valid = 1'b0;
   logic        csr_index = CSR_SAMPLE_RATE;
   logic [15:0] csr_data  = '0;
   wire         busy;
   wire         rsp_valid;
   rsp_type     rsp_item;
   wire         csr_ready;

   square_wave_note_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predicted status of the player, oldest first
   rsp_type pending_status [$];

   int fail_count     = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int audible_seen   = 0;
   int notes_started  = 0;
   int settings_count = 0;
   logic no_gaps      = 1'b0;

   // melody player shadow state
   logic [31:0]           song_mem [NOTE_DEPTH];
   logic [NOTE_DEPTH-1:0] mem_loaded;
   logic [6:0]            seq_pos, seq_len;
   logic                  seq_loop, seq_run, seq_tail, mute_st, tone_live;
   logic [15:0]           hold_ms, tone_len, tone_pos;
   int unsigned           ms_acc;
   logic [15:0]           cfg_rate;
   logic [7:0]            cfg_tail;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_square_wave_note_sequencer_unit: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic void player_clear();
      for (int i = 0; i < NOTE_DEPTH; i++) song_mem[i] = '0;
      mem_loaded = '0;
      seq_pos    = '0;
      seq_len    = '0;
      seq_loop   = 1'b0;
      seq_run    = 1'b0;
      seq_tail   = 1'b0;
      mute_st    = 1'b0;
      tone_live  = 1'b0;
      hold_ms    = '0;
      tone_len   = PERIOD_MIN;
      tone_pos   = '0;
      ms_acc     = 0;
      cfg_rate   = RATE_RESET;
      cfg_tail   = TAIL_RESET;
   endfunction

   function automatic int unsigned rate_used();
      return (cfg_rate == 16'd0) ? 1 : cfg_rate;
   endfunction

   // new tone: recompute the period and restart the phase
   function automatic void tone_select(input logic [15:0] hz);
      int unsigned p;
      p = PERIOD_MIN;
      if (hz != 16'd0) begin
         p = rate_used() / hz;
         if (p < PERIOD_MIN) p = PERIOD_MIN;
      end
      tone_live = (hz != 16'd0);
      tone_len  = p[15:0];
      tone_pos  = '0;
   endfunction

   // advance to the next note, wrapping or ending the song at the end
   function automatic void note_begin();
      logic [31:0] entry;
      if (seq_pos >= seq_len) begin
         if (seq_loop) begin
            seq_pos = '0;
         end else begin
            seq_run  = 1'b0;
            seq_tail = 1'b0;
            hold_ms  = '0;
            tone_select(16'd0);
            return;
         end
      end
      entry    = song_mem[seq_pos[5:0]];
      seq_pos  = seq_pos + 7'd1;
      hold_ms  = (entry[31:16] > cfg_tail) ? entry[31:16] - 16'(cfg_tail) : entry[31:16];
      seq_tail = 1'b0;
      notes_started++;
      tone_select(entry[15:0]);
   endfunction

   // one millisecond of sequencer time
   function automatic void ms_elapse();
      if (!seq_run || seq_len == 7'd0) return;
      if (hold_ms != 16'd0) hold_ms = hold_ms - 16'd1;
      if (hold_ms != 16'd0) return;
      if (!seq_tail) begin
         seq_tail = 1'b1;
         hold_ms  = 16'(cfg_tail);
         tone_select(16'd0);
      end else begin
         note_begin();
      end
   endfunction

   // apply one command and return the status the block should report
   function automatic rsp_type sequencer_response(input req_type it);
      rsp_type     r;
      int unsigned rate;
      r = '0;
      case (it.command)
         CMD_TICK: begin
            rate           = rate_used();
            r.sample_valid = 1'b1;
            if (tone_live && !mute_st) begin
               r.sample = (tone_pos < tone_len / 2) ? AMP_POS : AMP_NEG;
               tone_pos = tone_pos + 16'd1;
               if (tone_pos >= tone_len) tone_pos = '0;
            end
            ms_acc += MS_STEP;
            if (ms_acc >= rate) begin
               ms_acc -= rate;
               if (ms_acc >= rate) ms_acc = 0;
               ms_elapse();
            end
         end
         CMD_LOAD: begin
            song_mem[it.note_index]   = {it.note_ms, it.note_hz};
            mem_loaded[it.note_index] = 1'b1;
         end
         CMD_PLAY: begin
            seq_len  = (it.song_length > NOTE_DEPTH) ? 7'(NOTE_DEPTH) : it.song_length;
            seq_loop = it.repeat_req;
            seq_run  = 1'b1;
            seq_pos  = '0;
            ms_acc   = 0;
            seq_tail = 1'b0;
            hold_ms  = '0;
            if (seq_len == 7'd0) tone_select(16'd0);
            else note_begin();
         end
         CMD_STOP: begin
            seq_run  = 1'b0;
            seq_tail = 1'b0;
            hold_ms  = '0;
            tone_select(16'd0);
         end
         CMD_MUTE: mute_st = !mute_st;
         default: ;
      endcase
      r.playing = seq_run;
      r.muted   = mute_st;
      return r;
   endfunction

   // ------------------------------------------------------------ stimulus

   function automatic req_type make_item(input logic [2:0] cmd);
      req_type     it;
      logic [63:0] bits;
      bits       = {$urandom(), $urandom()};
      it         = bits[$bits(req_type)-1:0];
      it.command = cmd;
      return it;
   endfunction

   function automatic req_type load_item(input logic [5:0] slot, input logic [15:0] hz,
                                         input logic [15:0] ms);
      req_type it;
      it            = make_item(CMD_LOAD);
      it.note_index = slot;
      it.note_hz    = hz;
      it.note_ms    = ms;
      return it;
   endfunction

   function automatic req_type play_item(input logic [6:0] len, input logic rep);
      req_type it;
      it             = make_item(CMD_PLAY);
      it.song_length = len;
      it.repeat_req  = rep;
      return it;
   endfunction

   function automatic logic [15:0] random_hz();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'($urandom());
         2:       return 16'($urandom_range(1, 19));
         default: return 16'($urandom_range(20, 1500));
      endcase
   endfunction

   // a note with a short duration, now and then a very long one
   function automatic req_type note_item(input logic [5:0] slot, input int ms_top);
      logic [15:0] ms;
      ms = ($urandom_range(0, 39) == 0) ? 16'($urandom()) : 16'($urandom_range(0, ms_top));
      return load_item(slot, random_hz(), ms);
   endfunction

   // song length that only reaches slots already loaded
   function automatic logic [6:0] safe_length();
      int p;
      p = 0;
      while (p < NOTE_DEPTH && mem_loaded[p]) p++;
      if (p == NOTE_DEPTH) return 7'($urandom_range(0, 127));
      return 7'($urandom_range(0, p));
   endfunction

   // mostly ticks while a song runs, with the odd mute, stop or restart
   function automatic req_type song_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 90) return make_item(CMD_TICK);
      if (r < 95) return make_item(CMD_MUTE);
      if (r < 97) return make_item(CMD_STOP);
      if (r < 99) return play_item(safe_length(), 1'($urandom()));
      return make_item(3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)));
   endfunction

   function automatic req_type noise_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return make_item(CMD_TICK);
      if (r < 50) return make_item(CMD_LOAD);
      if (r < 65) return play_item(safe_length(), 1'($urandom()));
      if (r < 75) return make_item(CMD_STOP);
      if (r < 85) return make_item(CMD_MUTE);
      return make_item(3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)));
   endfunction

   function automatic int idle_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // send one item; start stays high when the next item follows at once
   task automatic issue_command(input req_type it);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_status.push_back(sequencer_response(it));
      items_sent++;
   endtask

   task automatic wait_drain();
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers while the block is idle
   task automatic program_rates(input logic [15:0] rate, input logic [7:0] tail);
      start <= 1'b0;
      wait_drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_SAMPLE_RATE;
      csr_data  <= rate;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_rate  = rate;
      csr_index <= CSR_TAIL_MS;
      csr_data  <= {8'($urandom()), tail};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_tail  = tail;
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // -------------------------------------------------------------- checker

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_status.size() == 0) begin
            $error("result with no item outstanding: sample %0d", rsp_item.sample);
            fail_count++;
         end else begin
            want = pending_status.pop_front();
            results_seen++;
            if (want.sample_valid && want.sample != 0) audible_seen++;
            if (rsp_item.sample !== want.sample) begin
               $error("sample: expected %0d, actual %0d", want.sample, rsp_item.sample);
               fail_count++;
            end
            if (rsp_item.sample_valid !== want.sample_valid) begin
               $error("sample_valid: expected %0b, actual %0b",
                      want.sample_valid, rsp_item.sample_valid);
               fail_count++;
            end
            if (rsp_item.playing !== want.playing) begin
               $error("playing: expected %0b, actual %0b", want.playing, rsp_item.playing);
               fail_count++;
            end
            if (rsp_item.muted !== want.muted) begin
               $error("muted: expected %0b, actual %0b", want.muted, rsp_item.muted);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // corner cases: idle status, reserved codes, rests, period floor,
   // empty song, zero hold, mute during a note, stop
   task automatic test_directed();
      issue_command(make_item(CMD_TICK));
      issue_command(make_item(CMD_RSVD_FIRST));
      issue_command(make_item(CMD_RSVD_MID));
      issue_command(make_item(CMD_RSVD_LAST));
      program_rates(16'd1000, 8'd2);
      issue_command(load_item(6'd0, 16'd0, 16'd1));
      issue_command(load_item(6'd1, 16'hFFFF, 16'd0));
      issue_command(load_item(6'd2, 16'd1, 16'hFFFF));
      issue_command(load_item(6'd63, 16'd440, 16'd3));
      issue_command(play_item(7'd0, 1'b0));
      issue_command(make_item(CMD_TICK));
      issue_command(make_item(CMD_STOP));
      issue_command(play_item(7'd3, 1'b1));
      repeat (8) issue_command(make_item(CMD_TICK));
      issue_command(make_item(CMD_MUTE));
      issue_command(make_item(CMD_TICK));
      issue_command(make_item(CMD_MUTE));
      issue_command(make_item(CMD_TICK));
      issue_command(make_item(CMD_STOP));
      issue_command(make_item(CMD_TICK));
   endtask

   // fill every slot, then play past the end with and without looping,
   // including lengths beyond the table depth
   task automatic test_full_table();
      program_rates(16'd1000, 8'd0);
      for (int i = 0; i < NOTE_DEPTH; i++)
         issue_command(load_item(6'(i), random_hz(), 16'($urandom_range(0, 1))));
      issue_command(play_item(7'd127, 1'b1));
      repeat (140) issue_command(make_item(CMD_TICK));
      issue_command(play_item(7'd65, 1'b0));
      repeat (135) issue_command(make_item(CMD_TICK));
      issue_command(make_item(CMD_STOP));
   endtask

   // random songs: load a few notes, play them, tick through them
   task automatic test_songs(input logic [15:0] rate, input logic [7:0] tail,
                             input int budget, input int ms_top, input int tick_top);
      int first;
      int n;
      program_rates(rate, tail);
      first = items_sent;
      while (items_sent - first < budget) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7) begin
            if (mute_st && $urandom_range(0, 4) != 0) issue_command(make_item(CMD_MUTE));
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) issue_command(note_item(6'(i), ms_top));
            if ($urandom_range(0, 4) == 0) issue_command(note_item(6'($urandom()), ms_top));
            if ($urandom_range(0, 3) == 0)
               issue_command(play_item(safe_length(), 1'($urandom())));
            else
               issue_command(play_item(7'(n), 1'($urandom())));
            repeat ($urandom_range(tick_top / 4, tick_top)) issue_command(song_step());
         end else begin
            repeat ($urandom_range(3, 8)) issue_command(noise_item());
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      player_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_table();
      test_songs(16'd1000, 8'd0, 300, 6, 40);
      test_songs(16'd0, 8'd3, 180, 6, 50);
      test_songs(16'd300, 8'd1, 180, 6, 40);
      test_songs(16'd1000, 8'd255, 220, 4, 120);
      test_songs(16'hFFFF, 8'd0, 220, 1, 150);
      test_songs(16'($urandom_range(2000, 8000)), 8'($urandom_range(0, 6)), 280, 4, 100);

      // let the last results come back
      start <= 1'b0;
      for (int c = 0; c < 200 && pending_status.size() != 0; c++) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (pending_status.size() != 0) begin
         $error("%0d expected results never arrived", pending_status.size());
         fail_count++;
      end

      $display("summary: %0d commands under %0d register settings, %0d results checked",
               items_sent, settings_count, results_seen);
      $display("summary: %0d notes started, %0d audible samples", notes_started, audible_seen);
      if (fail_count == 0) begin
         $display("tb_square_wave_note_sequencer_unit: done, clean");
      end else begin
         $display("tb_square_wave_note_sequencer_unit: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/swns_pkg.sv
hw/rtl/square_wave_note_sequencer_unit.sv
bench/tb_square_wave_note_sequencer_unit.sv
